FILE: hdl/etr_pkg.sv
// ---------------------------------------------------------------------------
// Echo range and stopwatch timer package
// Shared types, field widths, register codes and reset values for the timer.
// ---------------------------------------------------------------------------
package etr_pkg;

    // Default width of the shared tick counter.
    localparam int COUNT_WIDTH_DEF = 16;

    // Field widths.
    localparam int OP_W   = 3;
    localparam int MODE_W = 2;
    localparam int PW_W   = 16;
    localparam int DIST_W = 13;
    localparam int SW_W   = 7;
    localparam int CFG_W  = 16;
    localparam int IDX_W  = 2;

    // Register reset values.
    localparam logic [PW_W-1:0] ECHO_TIMEOUT_RST = 16'd60000;
    localparam logic [PW_W-1:0] MIN_ECHO_RST     = 16'd40;
    localparam logic [PW_W-1:0] SW_PERIOD_RST    = 16'd6249;
    localparam logic [SW_W-1:0] SW_LIMIT_RST     = 7'd100;

    // Distance in mm is (width*5+29)/58. Halving first leaves a division by 29,
    // done as a multiply by ceil(2^26/29) and a shift; exact for every 16-bit width.
    localparam int              DIST_SUM_W = 19;
    localparam int              DIST_Y_W   = 18;
    localparam int              DIST_M_W   = 22;
    localparam int              DIST_P_W   = DIST_Y_W + DIST_M_W;
    localparam int              DIST_SHIFT = 26;
    localparam logic [2:0]      DIST_SCALE = 3'd5;
    localparam logic [4:0]      DIST_BIAS  = 5'd29;
    localparam logic [DIST_M_W-1:0] DIST_MUL = 22'd2314099;

    typedef enum logic [MODE_W-1:0] {
        RUN_IDLE      = 2'd0,
        RUN_ECHO      = 2'd1,
        RUN_STOPWATCH = 2'd2
    } t_mode;

    typedef enum logic [OP_W-1:0] {
        OP_TICK        = 3'd0,
        OP_EDGE        = 3'd1,
        OP_START_RANGE = 3'd2,
        OP_START_SW    = 3'd3,
        OP_STOP_SW     = 3'd4
    } t_op;

    typedef enum logic [IDX_W-1:0] {
        REG_ECHO_TIMEOUT = 2'd0,
        REG_MIN_ECHO     = 2'd1,
        REG_SW_PERIOD    = 2'd2,
        REG_SW_LIMIT     = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            echo_level;
    } t_in_beat;

    typedef struct packed {
        logic [MODE_W-1:0] mode_now;
        logic              done_flag;
        logic              valid_flag;
        logic              timeout_flag;
        logic [PW_W-1:0]   pulse_width;
        logic [DIST_W-1:0] distance_mm;
        logic [SW_W-1:0]   stopwatch_count;
        logic              trigger_request;
    } t_out_beat;

    typedef struct packed {
        logic [PW_W-1:0] echo_timeout_ticks;
        logic [PW_W-1:0] min_echo_ticks;
        logic [PW_W-1:0] stopwatch_period_ticks;
        logic [SW_W-1:0] stopwatch_limit;
    } t_cfg;

endpackage

FILE: hdl/etr_cfg_regs.sv
// ---------------------------------------------------------------------------
// Timer configuration registers
// Holds the four configuration registers, written through a plain write port.
// ---------------------------------------------------------------------------
module etr_cfg_regs (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [etr_pkg::IDX_W-1:0] i_cfg_index,
    input  logic [etr_pkg::CFG_W-1:0] i_cfg_data,
    output etr_pkg::t_cfg             o_cfg
);

    etr_pkg::t_cfg r_cfg;
    etr_pkg::t_cfg n_cfg;

    // Decode the register index and merge the write data.
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (etr_pkg::t_reg_idx'(i_cfg_index))
                etr_pkg::REG_ECHO_TIMEOUT: begin
                    n_cfg.echo_timeout_ticks = i_cfg_data;
                end
                etr_pkg::REG_MIN_ECHO: begin
                    n_cfg.min_echo_ticks = i_cfg_data;
                end
                etr_pkg::REG_SW_PERIOD: begin
                    n_cfg.stopwatch_period_ticks = i_cfg_data;
                end
                etr_pkg::REG_SW_LIMIT: begin
                    n_cfg.stopwatch_limit = i_cfg_data[etr_pkg::SW_W-1:0];
                end
                default: begin
                    n_cfg = r_cfg;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.echo_timeout_ticks     <= etr_pkg::ECHO_TIMEOUT_RST;
            r_cfg.min_echo_ticks         <= etr_pkg::MIN_ECHO_RST;
            r_cfg.stopwatch_period_ticks <= etr_pkg::SW_PERIOD_RST;
            r_cfg.stopwatch_limit        <= etr_pkg::SW_LIMIT_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: hdl/etr_core.sv
// ---------------------------------------------------------------------------
// Timer state update
// Applies one input beat to the shared tick counter and the echo and
// stopwatch state; the state registers double as the first result stage.
// ---------------------------------------------------------------------------
module etr_core #(
    parameter int COUNT_WIDTH = etr_pkg::COUNT_WIDTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  etr_pkg::t_cfg     i_cfg,
    input  logic              i_load,
    input  etr_pkg::t_in_beat i_beat,
    output etr_pkg::t_out_beat o_result
);

    // Compares run at the wider of the counter and the 16-bit registers.
    localparam int CMP_W = (COUNT_WIDTH > etr_pkg::PW_W) ? COUNT_WIDTH : etr_pkg::PW_W;

    etr_pkg::t_mode              r_mode, n_mode;
    logic                        r_armed, n_armed;
    logic [COUNT_WIDTH-1:0]      r_tick, n_tick;
    logic [etr_pkg::PW_W-1:0]    r_captured, n_captured;
    logic [etr_pkg::SW_W-1:0]    r_elapsed, n_elapsed;
    logic                        r_done, n_done;
    logic                        r_valid, n_valid;
    logic                        r_timeout, n_timeout;
    logic                        r_trig, n_trig;

    logic [COUNT_WIDTH-1:0]      tick_inc;
    logic [CMP_W-1:0]            tick_ext;
    logic [CMP_W-1:0]            inc_ext;
    logic [etr_pkg::SW_W:0]      sw_next;

    assign tick_inc = r_tick + 1'b1;
    assign tick_ext = CMP_W'(r_tick);
    assign inc_ext  = CMP_W'(tick_inc);
    assign sw_next  = {1'b0, r_elapsed} + 1'b1;

    // Next state for one accepted beat.
    always_comb begin
        n_mode     = r_mode;
        n_armed    = r_armed;
        n_tick     = r_tick;
        n_captured = r_captured;
        n_elapsed  = r_elapsed;
        n_done     = r_done;
        n_valid    = r_valid;
        n_timeout  = r_timeout;
        n_trig     = r_trig;
        if (i_load) begin
            n_trig = (etr_pkg::t_op'(i_beat.op) == etr_pkg::OP_START_RANGE);
            case (etr_pkg::t_op'(i_beat.op))
                etr_pkg::OP_TICK: begin
                    if (r_mode == etr_pkg::RUN_ECHO) begin
                        n_tick = tick_inc;
                        if (inc_ext == CMP_W'(i_cfg.echo_timeout_ticks)) begin
                            n_valid   = 1'b0;
                            n_done    = 1'b1;
                            n_timeout = 1'b1;
                            n_mode    = etr_pkg::RUN_IDLE;
                            n_armed   = 1'b0;
                        end
                    end else if (r_mode == etr_pkg::RUN_STOPWATCH) begin
                        if (tick_ext == CMP_W'(i_cfg.stopwatch_period_ticks)) begin
                            n_tick = '0;
                            if (sw_next > {1'b0, i_cfg.stopwatch_limit}) begin
                                n_elapsed = i_cfg.stopwatch_limit;
                                n_timeout = 1'b1;
                                n_mode    = etr_pkg::RUN_IDLE;
                            end else begin
                                n_elapsed = sw_next[etr_pkg::SW_W-1:0];
                            end
                        end else begin
                            n_tick = tick_inc;
                        end
                    end
                end
                etr_pkg::OP_EDGE: begin
                    if (r_mode == etr_pkg::RUN_ECHO) begin
                        if (i_beat.echo_level) begin
                            n_tick  = '0;
                            n_armed = 1'b1;
                        end else if (r_armed) begin
                            if (tick_ext < CMP_W'(i_cfg.min_echo_ticks)) begin
                                // Pulse too short: drop it and wait for a new rise.
                                n_armed = 1'b0;
                                n_tick  = '0;
                            end else begin
                                n_captured = etr_pkg::PW_W'(r_tick);
                                n_valid    = 1'b1;
                                n_done     = 1'b1;
                                n_mode     = etr_pkg::RUN_IDLE;
                                n_armed    = 1'b0;
                            end
                        end
                    end
                end
                etr_pkg::OP_START_RANGE: begin
                    n_done     = 1'b0;
                    n_valid    = 1'b0;
                    n_timeout  = 1'b0;
                    n_captured = '0;
                    n_armed    = 1'b0;
                    n_tick     = '0;
                    n_mode     = etr_pkg::RUN_ECHO;
                end
                etr_pkg::OP_START_SW: begin
                    n_elapsed = '0;
                    n_timeout = 1'b0;
                    n_tick    = '0;
                    n_mode    = etr_pkg::RUN_STOPWATCH;
                end
                etr_pkg::OP_STOP_SW: begin
                    n_mode = etr_pkg::RUN_IDLE;
                end
                default: begin
                    n_mode = r_mode;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= etr_pkg::RUN_IDLE;
            r_armed    <= 1'b0;
            r_tick     <= '0;
            r_captured <= '0;
            r_elapsed  <= '0;
            r_done     <= 1'b0;
            r_valid    <= 1'b0;
            r_timeout  <= 1'b0;
            r_trig     <= 1'b0;
        end else begin
            r_mode     <= n_mode;
            r_armed    <= n_armed;
            r_tick     <= n_tick;
            r_captured <= n_captured;
            r_elapsed  <= n_elapsed;
            r_done     <= n_done;
            r_valid    <= n_valid;
            r_timeout  <= n_timeout;
            r_trig     <= n_trig;
        end
    end

    // Result fields straight from the state; distance is filled in downstream.
    always_comb begin
        o_result.mode_now        = r_mode;
        o_result.done_flag       = r_done;
        o_result.valid_flag      = r_valid;
        o_result.timeout_flag    = r_timeout;
        o_result.pulse_width     = r_captured;
        o_result.distance_mm     = '0;
        o_result.stopwatch_count = r_elapsed;
        o_result.trigger_request = r_trig;
    end

endmodule

FILE: hdl/etr_dist.sv
// ---------------------------------------------------------------------------
// Distance conversion stage
// Converts the captured pulse width to millimeters and holds the output beat.
// ---------------------------------------------------------------------------
module etr_dist (
    input  logic               i_clk,
    input  logic               i_load,
    input  etr_pkg::t_out_beat i_beat,
    output etr_pkg::t_out_beat o_beat
);

    etr_pkg::t_out_beat                r_beat;
    etr_pkg::t_out_beat                n_beat;
    logic [etr_pkg::DIST_SUM_W-1:0]    dist_sum;
    logic [etr_pkg::DIST_Y_W-1:0]      dist_half;
    logic [etr_pkg::DIST_P_W-1:0]      dist_prod;

    // (width*5+29)/58 as ((width*5+29)>>1) * ceil(2^26/29) >> 26.
    assign dist_sum  = etr_pkg::DIST_SUM_W'(i_beat.pulse_width) * etr_pkg::DIST_SCALE
                       + etr_pkg::DIST_SUM_W'(etr_pkg::DIST_BIAS);
    assign dist_half = dist_sum[etr_pkg::DIST_SUM_W-1:1];
    assign dist_prod = etr_pkg::DIST_P_W'(dist_half) * etr_pkg::DIST_P_W'(etr_pkg::DIST_MUL);

    always_comb begin
        n_beat = i_beat;
        n_beat.distance_mm =
            dist_prod[etr_pkg::DIST_SHIFT +: etr_pkg::DIST_W];
    end

    // Payload register; loads only when the stage takes a new beat.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_beat <= n_beat;
        end
    end

    assign o_beat = r_beat;

endmodule

FILE: hdl/echo_range_and_stopwatch_timer_unit.sv
// Path: an accepted beat updates the core state registers, then the distance stage register.
// Throughput: one beat per cycle while the output is not stalled; the counter and mode
// update set the first stage, the distance multiplier sets the second.
// Reset: synchronous, active low; clears mode, counters, flags and pipeline valids,
// and loads the configuration registers with their default values.
// ---------------------------------------------------------------------------
// Echo range and stopwatch timer
// Top level: configuration registers, state update stage and distance stage
// joined by a two-stage valid/stall pipeline.
// ---------------------------------------------------------------------------
module echo_range_and_stopwatch_timer_unit #(
    parameter int COUNT_WIDTH = etr_pkg::COUNT_WIDTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [etr_pkg::IDX_W-1:0] i_cfg_index,
    input  logic [etr_pkg::CFG_W-1:0] i_cfg_data,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  etr_pkg::t_in_beat         i_in_beat,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output etr_pkg::t_out_beat        o_out_beat
);

    etr_pkg::t_cfg      cfg;
    etr_pkg::t_out_beat core_result;
    logic               r_s1_valid, n_s1_valid;
    logic               r_s2_valid, n_s2_valid;
    logic               s2_free;
    logic               s1_free;
    logic               s1_advance;
    logic               in_accept;

    // Pipeline handshake: each stage moves when the one after it can take a beat.
    assign s2_free    = !r_s2_valid || !i_out_stall;
    assign s1_advance = r_s1_valid && s2_free;
    assign s1_free    = !r_s1_valid || s2_free;
    assign o_in_stall = !s1_free;
    assign in_accept  = i_in_valid && s1_free;
    assign n_s1_valid = in_accept || (r_s1_valid && !s2_free);
    assign n_s2_valid = s1_advance || (r_s2_valid && i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            r_s1_valid <= n_s1_valid;
            r_s2_valid <= n_s2_valid;
        end
    end

    assign o_out_valid = r_s2_valid;

    etr_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    etr_core #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_load   (in_accept),
        .i_beat   (i_in_beat),
        .o_result (core_result)
    );

    etr_dist u_dist (
        .i_clk  (i_clk),
        .i_load (s1_advance),
        .i_beat (core_result),
        .o_beat (o_out_beat)
    );

endmodule

FILE: hdl/etr_checker.sv
// ---------------------------------------------------------------------------
// Timer port checker
// Watches the top level's ports and checks input and output handshake and result rules.
// ---------------------------------------------------------------------------
module etr_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      o_in_stall,
    input logic                      o_out_valid,
    input logic                      i_out_stall,
    input etr_pkg::t_out_beat        o_out_beat
);

    // A stalled output beat stays put.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_beat))
        else $error("output beat changed while stalled");

    // Input is held back only while a finished result waits downstream.
    a_in_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without a waiting output beat");

    // A range start leaves a fresh echo measurement.
    a_trigger_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_beat.trigger_request |->
            o_out_beat.mode_now == etr_pkg::RUN_ECHO && !o_out_beat.done_flag &&
            !o_out_beat.valid_flag && !o_out_beat.timeout_flag &&
            o_out_beat.pulse_width == '0)
        else $error("range start result not in a cleared echo state");

    // A valid capture always comes with done.
    a_valid_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_beat.valid_flag |-> o_out_beat.done_flag)
        else $error("valid flag without done flag");

    // An empty capture maps to zero distance.
    a_zero_distance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_beat.pulse_width == '0 |-> o_out_beat.distance_mm == '0)
        else $error("nonzero distance for zero pulse width");

endmodule

bind echo_range_and_stopwatch_timer_unit etr_checker u_etr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_beat  (o_out_beat)
);

FILE: bench/echo_range_and_stopwatch_timer_unit_tb.sv
// ---------------------------------------------------------------------------
// Echo range and stopwatch timer testbench
// Sends tick, echo edge and mode beats through the valid/stall input, predicts
// every status beat with a behavioral copy of the timer, and checks each
// output beat field by field under random input gaps and output stalls.
// ---------------------------------------------------------------------------
module testbench;

    localparam int COUNT_W       = etr_pkg::COUNT_WIDTH_DEF;
    localparam int OP_CODE_MAX   = (1 << etr_pkg::OP_W) - 1;
    localparam int SETTLE_CYCLES = 4;
    localparam int HOLD_CYCLES   = 60;
    localparam int REPORT_MAX    = 40;
    localparam int LIMIT_TIME    = 4000000;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n;
    logic                        i_cfg_we;
    logic [etr_pkg::IDX_W-1:0]   i_cfg_index;
    logic [etr_pkg::CFG_W-1:0]   i_cfg_data;
    logic                        i_in_valid;
    logic                        o_in_stall;
    etr_pkg::t_in_beat           i_in_beat;
    logic                        o_out_valid;
    logic                        i_out_stall;
    etr_pkg::t_out_beat          o_out_beat;

    // Predicted timer state and its register copies.
    etr_pkg::t_mode              p_mode;
    logic                        p_armed;
    logic [COUNT_W-1:0]          p_ticks;
    logic [etr_pkg::PW_W-1:0]    p_width;
    logic [etr_pkg::SW_W-1:0]    p_periods;
    logic                        p_done;
    logic                        p_valid;
    logic                        p_timeout;
    logic [etr_pkg::PW_W-1:0]    c_timeout;
    logic [etr_pkg::PW_W-1:0]    c_min_width;
    logic [etr_pkg::PW_W-1:0]    c_period;
    logic [etr_pkg::SW_W-1:0]    c_limit;

    etr_pkg::t_out_beat          pending_status[$];
    int                          mismatch_count = 0;
    int                          status_seen = 0;
    int                          beats_sent = 0;
    int                          burst_left = 0;
    bit                          hold_output = 1'b0;

    echo_range_and_stopwatch_timer_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_beat   (i_in_beat),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_beat  (o_out_beat)
    );

    // Clock with an 8 unit period.
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Run limit in case the handshake hangs.
    initial begin
        #(LIMIT_TIME);
        $display("** echo_range_and_stopwatch_timer_unit: FAILED **");
        $finish;
    end

    // Print one line per mismatch, up to a cap, and count all of them.
    task automatic report_mismatch(input string msg);
        if (mismatch_count < REPORT_MAX) begin
            $display("mismatch: %s", msg);
        end
        mismatch_count++;
    endtask

    task automatic compare_field(input string name, input logic [15:0] got,
                                 input logic [15:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("status beat %0d %s got %0h expected %0h",
                                      status_seen, name, got, want));
        end
    endtask

    task automatic reset_timer_model();
        p_mode      = etr_pkg::RUN_IDLE;
        p_armed     = 1'b0;
        p_ticks     = '0;
        p_width     = '0;
        p_periods   = '0;
        p_done      = 1'b0;
        p_valid     = 1'b0;
        p_timeout   = 1'b0;
        c_timeout   = etr_pkg::ECHO_TIMEOUT_RST;
        c_min_width = etr_pkg::MIN_ECHO_RST;
        c_period    = etr_pkg::SW_PERIOD_RST;
        c_limit     = etr_pkg::SW_LIMIT_RST;
    endtask

    // Apply one input beat to the predicted state and form the status it yields.
    task automatic step_timer_state(input etr_pkg::t_in_beat beat,
                                    output etr_pkg::t_out_beat status);
        logic [etr_pkg::SW_W:0] next_count;
        int unsigned            mm_value;
        next_count = '0;
        case (beat.op)
            etr_pkg::OP_TICK: begin
                if (p_mode == etr_pkg::RUN_ECHO) begin
                    p_ticks = p_ticks + 1'b1;
                    if (p_ticks == c_timeout) begin
                        p_valid   = 1'b0;
                        p_done    = 1'b1;
                        p_timeout = 1'b1;
                        p_mode    = etr_pkg::RUN_IDLE;
                        p_armed   = 1'b0;
                    end
                end else if (p_mode == etr_pkg::RUN_STOPWATCH) begin
                    if (p_ticks == c_period) begin
                        next_count = p_periods + 1'b1;
                        p_ticks    = '0;
                        if (next_count > c_limit) begin
                            next_count = c_limit;
                            p_timeout  = 1'b1;
                            p_mode     = etr_pkg::RUN_IDLE;
                        end
                        p_periods = next_count[etr_pkg::SW_W-1:0];
                    end else begin
                        p_ticks = p_ticks + 1'b1;
                    end
                end
            end
            etr_pkg::OP_EDGE: begin
                if (p_mode == etr_pkg::RUN_ECHO) begin
                    if (beat.echo_level) begin
                        p_ticks = '0;
                        p_armed = 1'b1;
                    end else if (p_armed) begin
                        if (p_ticks < c_min_width) begin
                            // Pulse too short: disarm and wait for another rising edge.
                            p_armed = 1'b0;
                            p_ticks = '0;
                        end else begin
                            p_width = p_ticks[etr_pkg::PW_W-1:0];
                            p_valid = 1'b1;
                            p_done  = 1'b1;
                            p_mode  = etr_pkg::RUN_IDLE;
                            p_armed = 1'b0;
                        end
                    end
                end
            end
            etr_pkg::OP_START_RANGE: begin
                p_done    = 1'b0;
                p_valid   = 1'b0;
                p_timeout = 1'b0;
                p_width   = '0;
                p_armed   = 1'b0;
                p_ticks   = '0;
                p_mode    = etr_pkg::RUN_ECHO;
            end
            etr_pkg::OP_START_SW: begin
                p_periods = '0;
                p_timeout = 1'b0;
                p_ticks   = '0;
                p_mode    = etr_pkg::RUN_STOPWATCH;
            end
            etr_pkg::OP_STOP_SW: begin
                p_mode = etr_pkg::RUN_IDLE;
            end
            default: begin
            end
        endcase
        // Millimeters from ticks, rounded: (width * 5 + 29) / 58.
        mm_value = (32'(p_width) * 5 + 29) / 58;
        status.mode_now        = p_mode;
        status.done_flag       = p_done;
        status.valid_flag      = p_valid;
        status.timeout_flag    = p_timeout;
        status.pulse_width     = p_width;
        status.distance_mm     = mm_value[etr_pkg::DIST_W-1:0];
        status.stopwatch_count = p_periods;
        status.trigger_request = (beat.op == etr_pkg::OP_START_RANGE);
    endtask

    // Offer one beat, hold it until accepted, then predict its status.
    // Bursts of random length are separated by random gaps.
    task automatic send_beat(input etr_pkg::t_in_beat beat);
        etr_pkg::t_out_beat want;
        i_in_valid <= 1'b1;
        i_in_beat  <= beat;
        do @(posedge i_clk); while (o_in_stall);
        step_timer_state(beat, want);
        pending_status.push_back(want);
        beats_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge i_clk);
            burst_left = ($urandom_range(3, 0) == 0) ? $urandom_range(80, 30)
                                                      : $urandom_range(12, 0);
        end
    endtask

    task automatic send_op(input logic [etr_pkg::OP_W-1:0] op, input logic level);
        etr_pkg::t_in_beat beat;
        beat.op         = op;
        beat.echo_level = level;
        send_beat(beat);
    endtask

    task automatic send_ticks(input int count);
        repeat (count) send_op(etr_pkg::OP_TICK, 1'($urandom_range(1, 0)));
    endtask

    task automatic send_noise();
        send_op(3'($urandom_range(OP_CODE_MAX, 0)), 1'($urandom_range(1, 0)));
    endtask

    // Ticks with the odd stray beat mixed in.
    task automatic send_noisy_ticks(input int count);
        repeat (count) begin
            if ($urandom_range(19, 0) == 0) begin
                send_noise();
            end else begin
                send_op(etr_pkg::OP_TICK, 1'($urandom_range(1, 0)));
            end
        end
    endtask

    // Stop offering beats and wait until every predicted status has come out.
    task automatic settle_pipeline();
        i_in_valid <= 1'b0;
        while (pending_status.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Register write; only called while the pipeline is empty.
    task automatic write_reg(input etr_pkg::t_reg_idx idx,
                             input logic [etr_pkg::CFG_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            etr_pkg::REG_ECHO_TIMEOUT: c_timeout   = data;
            etr_pkg::REG_MIN_ECHO:     c_min_width = data;
            etr_pkg::REG_SW_PERIOD:    c_period    = data;
            etr_pkg::REG_SW_LIMIT:     c_limit     = data[etr_pkg::SW_W-1:0];
            default: begin
            end
        endcase
    endtask

    // Random register settings, mostly small so that limits are reached quickly.
    task automatic randomize_settings();
        logic [etr_pkg::CFG_W-1:0] value;
        if ($urandom_range(1, 0) == 0) begin
            value = ($urandom_range(7, 0) == 0) ? (($urandom_range(1, 0) == 0) ? 16'd1 : 16'hFFFF)
                                                : 16'($urandom_range(120, 8));
            write_reg(etr_pkg::REG_ECHO_TIMEOUT, value);
        end
        if ($urandom_range(1, 0) == 0) begin
            value = ($urandom_range(7, 0) == 0) ? (($urandom_range(1, 0) == 0) ? 16'd0 : 16'hFFFF)
                                                : 16'($urandom_range(60, 0));
            write_reg(etr_pkg::REG_MIN_ECHO, value);
        end
        if ($urandom_range(1, 0) == 0) begin
            value = ($urandom_range(7, 0) == 0) ? (($urandom_range(1, 0) == 0) ? 16'd0 : 16'hFFFF)
                                                : 16'($urandom_range(6, 0));
            write_reg(etr_pkg::REG_SW_PERIOD, value);
        end
        if ($urandom_range(1, 0) == 0) begin
            value = ($urandom_range(7, 0) == 0) ? (($urandom_range(1, 0) == 0) ? 16'd0 : 16'd127)
                                                : 16'($urandom_range(8, 1));
            // Bits above the register width carry junk that must be dropped.
            value[etr_pkg::CFG_W-1:etr_pkg::SW_W] =
                ($urandom_range(3, 0) == 0) ? 9'($urandom) : '0;
            write_reg(etr_pkg::REG_SW_LIMIT, value);
        end
    endtask

    // One ranging measurement: start, optional stray edge, rising edge, a pulse
    // that is short, long enough, or runs into the timeout, then the falling edge.
    task automatic echo_sequence();
        int span;
        send_op(etr_pkg::OP_START_RANGE, 1'($urandom_range(1, 0)));
        if ($urandom_range(5, 0) == 0) begin
            send_op(etr_pkg::OP_EDGE, 1'b0);
        end
        send_ticks($urandom_range(3, 0));
        send_op(etr_pkg::OP_EDGE, 1'b1);
        case ($urandom_range(5, 0))
            0: span = (c_min_width > 0 && c_min_width <= 200) ?
                      $urandom_range(int'(c_min_width) - 1, 0) : $urandom_range(10, 0);
            1: span = (c_timeout <= 200) ? int'(c_timeout) + 2 : $urandom_range(30, 0);
            default: span = (c_min_width <= 200) ? int'(c_min_width) + $urandom_range(60, 0)
                                                 : $urandom_range(60, 0);
        endcase
        send_noisy_ticks(span);
        send_op(etr_pkg::OP_EDGE, 1'b0);
        send_ticks($urandom_range(2, 0));
    endtask

    // One stopwatch session, sometimes paused and restarted.
    task automatic stopwatch_sequence();
        send_op(etr_pkg::OP_START_SW, 1'($urandom_range(1, 0)));
        send_noisy_ticks($urandom_range(60, 1));
        if ($urandom_range(2, 0) == 0) begin
            send_op(etr_pkg::OP_STOP_SW, 1'($urandom_range(1, 0)));
            send_ticks($urandom_range(3, 0));
            send_op(etr_pkg::OP_START_SW, 1'($urandom_range(1, 0)));
            send_noisy_ticks($urandom_range(20, 1));
        end
        send_op(etr_pkg::OP_STOP_SW, 1'($urandom_range(1, 0)));
    endtask

    // Idle behavior: ticks, edges, stop and spare op codes change nothing.
    task automatic test_idle_ops();
        send_op(etr_pkg::OP_TICK, 1'b0);
        send_op(etr_pkg::OP_EDGE, 1'b1);
        send_op(etr_pkg::OP_EDGE, 1'b0);
        send_op(etr_pkg::OP_STOP_SW, 1'b1);
        for (int k = int'(etr_pkg::OP_STOP_SW) + 1; k <= OP_CODE_MAX; k++) begin
            send_op(3'(k), 1'(k));
        end
        settle_pipeline();
    endtask

    // Measurements under the settings that reset leaves behind.
    task automatic test_default_settings();
        echo_sequence();
        echo_sequence();
        send_op(etr_pkg::OP_START_SW, 1'b0);
        send_ticks(20);
        send_op(etr_pkg::OP_STOP_SW, 1'b0);
        settle_pipeline();
    endtask

    // Capture with the widest timeout and no minimum; a second rising edge
    // restarts the count and a falling edge before arming is ignored.
    task automatic test_echo_capture();
        write_reg(etr_pkg::REG_ECHO_TIMEOUT, 16'hFFFF);
        write_reg(etr_pkg::REG_MIN_ECHO, 16'h0000);
        send_op(etr_pkg::OP_START_RANGE, 1'b0);
        send_op(etr_pkg::OP_EDGE, 1'b0);
        send_op(etr_pkg::OP_EDGE, 1'b1);
        send_ticks(3);
        send_op(etr_pkg::OP_EDGE, 1'b1);
        send_ticks(2);
        send_op(etr_pkg::OP_EDGE, 1'b0);
        send_op(etr_pkg::OP_TICK, 1'b1);
        settle_pipeline();
    endtask

    // A pulse below the minimum disarms; a later full pulse is captured.
    task automatic test_short_pulse();
        write_reg(etr_pkg::REG_MIN_ECHO, 16'd3);
        send_op(etr_pkg::OP_START_RANGE, 1'b1);
        send_op(etr_pkg::OP_EDGE, 1'b1);
        send_ticks(1);
        send_op(etr_pkg::OP_EDGE, 1'b0);
        send_op(etr_pkg::OP_EDGE, 1'b0);
        send_op(etr_pkg::OP_EDGE, 1'b1);
        send_ticks(3);
        send_op(etr_pkg::OP_EDGE, 1'b0);
        settle_pipeline();
    endtask

    // Timeout on the first tick, before and after the rising edge.
    task automatic test_echo_timeout();
        write_reg(etr_pkg::REG_ECHO_TIMEOUT, 16'd1);
        send_op(etr_pkg::OP_START_RANGE, 1'b0);
        send_op(etr_pkg::OP_TICK, 1'b0);
        send_op(etr_pkg::OP_START_RANGE, 1'b1);
        send_op(etr_pkg::OP_EDGE, 1'b1);
        send_op(etr_pkg::OP_TICK, 1'b1);
        settle_pipeline();
    endtask

    // Zero limit clamps on the first period; a small limit clamps after wraps.
    // Done and valid are kept across a stopwatch start.
    task automatic test_stopwatch_limits();
        write_reg(etr_pkg::REG_SW_PERIOD, 16'd0);
        write_reg(etr_pkg::REG_SW_LIMIT, 16'd0);
        send_op(etr_pkg::OP_START_SW, 1'b0);
        send_ticks(2);
        settle_pipeline();
        write_reg(etr_pkg::REG_SW_PERIOD, 16'd1);
        write_reg(etr_pkg::REG_SW_LIMIT, 16'd2);
        send_op(etr_pkg::OP_START_SW, 1'b1);
        send_ticks(7);
        settle_pipeline();
    endtask

    // The period is lowered below the running count, so the counter runs on;
    // then the longest period and the largest limit, with junk upper data bits.
    task automatic test_period_lowered();
        write_reg(etr_pkg::REG_SW_PERIOD, 16'd50);
        write_reg(etr_pkg::REG_SW_LIMIT, {9'($urandom) | 9'h1, 7'd127});
        send_op(etr_pkg::OP_START_SW, 1'b0);
        send_ticks(8);
        settle_pipeline();
        write_reg(etr_pkg::REG_SW_PERIOD, 16'd3);
        send_ticks(6);
        send_op(etr_pkg::OP_STOP_SW, 1'b0);
        send_op(etr_pkg::OP_TICK, 1'b0);
        settle_pipeline();
        write_reg(etr_pkg::REG_SW_PERIOD, 16'hFFFF);
        send_op(etr_pkg::OP_START_SW, 1'b1);
        send_ticks(3);
        send_op(etr_pkg::OP_STOP_SW, 1'b1);
        settle_pipeline();
    endtask

    // Random phases; each phase picks new settings and runs a few sessions.
    task automatic test_random_sessions(input int target, input int echo_pct);
        int start_count;
        start_count = beats_sent;
        while (beats_sent - start_count < target) begin
            settle_pipeline();
            randomize_settings();
            repeat ($urandom_range(3, 1)) begin
                if ($urandom_range(99, 0) < echo_pct) begin
                    echo_sequence();
                end else begin
                    stopwatch_sequence();
                end
                if ($urandom_range(3, 0) == 0) begin
                    send_noise();
                end
            end
        end
        settle_pipeline();
    endtask

    // The receiver holds off while the sender keeps offering beats back to back.
    task automatic test_output_backpressure();
        hold_output = 1'b1;
        burst_left  = 1000;
        echo_sequence();
        stopwatch_sequence();
        burst_left = 0;
        settle_pipeline();
    endtask

    // Receiver stall pattern: segments of random stall density, plus a long
    // hold-off when a test asks for one.
    initial begin : out_stall_pattern
        int seg_left;
        int stall_pct;
        int held;
        seg_left    = 0;
        stall_pct   = 0;
        held        = 0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (seg_left == 0) begin
                seg_left = $urandom_range(200, 20);
                case ($urandom_range(3, 0))
                    0: stall_pct = 0;
                    1: stall_pct = 20;
                    2: stall_pct = 50;
                    default: stall_pct = 75;
                endcase
            end
            seg_left--;
            if (hold_output) begin
                i_out_stall <= 1'b1;
                held++;
                if (held >= HOLD_CYCLES) begin
                    hold_output = 1'b0;
                    held        = 0;
                end
            end else begin
                i_out_stall <= ($urandom_range(99, 0) < stall_pct);
            end
        end
    end

    // Compare every accepted output beat with the oldest predicted status.
    always @(posedge i_clk) begin : status_monitor
        etr_pkg::t_out_beat want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_status.size() == 0) begin
                report_mismatch($sformatf("status beat %0d arrived with none expected",
                                          status_seen));
            end else begin
                want = pending_status.pop_front();
                compare_field("mode_now", o_out_beat.mode_now, want.mode_now);
                compare_field("done_flag", o_out_beat.done_flag, want.done_flag);
                compare_field("valid_flag", o_out_beat.valid_flag, want.valid_flag);
                compare_field("timeout_flag", o_out_beat.timeout_flag, want.timeout_flag);
                compare_field("pulse_width", o_out_beat.pulse_width, want.pulse_width);
                compare_field("distance_mm", o_out_beat.distance_mm, want.distance_mm);
                compare_field("stopwatch_count", o_out_beat.stopwatch_count,
                              want.stopwatch_count);
                compare_field("trigger_request", o_out_beat.trigger_request,
                              want.trigger_request);
            end
            status_seen++;
        end
    end

    // Reset, then the tests in turn, then the verdict.
    initial begin
        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= etr_pkg::REG_ECHO_TIMEOUT;
        i_cfg_data  <= '0;
        i_in_valid  <= 1'b0;
        i_in_beat   <= '0;
        reset_timer_model();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_idle_ops();
        test_default_settings();
        test_echo_capture();
        test_short_pulse();
        test_echo_timeout();
        test_stopwatch_limits();
        test_period_lowered();
        test_random_sessions(80, 80);
        test_output_backpressure();
        test_random_sessions(40, 25);

        settle_pipeline();
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0 && pending_status.size() == 0) begin
            $display("** echo_range_and_stopwatch_timer_unit: PASSED **");
        end else begin
            $display("** echo_range_and_stopwatch_timer_unit: FAILED **");
        end
        $finish;
    end

endmodule

FILE: sim.f
hdl/etr_pkg.sv
hdl/etr_cfg_regs.sv
hdl/etr_core.sv
hdl/etr_dist.sv
hdl/echo_range_and_stopwatch_timer_unit.sv
hdl/etr_checker.sv
bench/echo_range_and_stopwatch_timer_unit_tb.sv
